[hdl/rrqs_pkg.sv]
// Shared types and constants of the round-robin quantum scheduler.
// No dependencies; every other file of the block refers to this package.
package rrqs_pkg;

    typedef logic [3:0]  t_pid;
    typedef logic [15:0] t_svc;
    typedef logic [2:0]  t_status;
    typedef logic [15:0] t_ftime;
    typedef logic [4:0]  t_qcnt;
    typedef logic [7:0]  t_quantum;

    localparam logic OP_ADMIT = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam t_status ST_ADMITTED  = 3'd0;
    localparam t_status ST_FULL_DROP = 3'd1;
    localparam t_status ST_IDLE_TICK = 3'd2;
    localparam t_status ST_RAN       = 3'd3;
    localparam t_status ST_FINISHED  = 3'd4;
    localparam t_status ST_PREEMPTED = 3'd5;

    localparam t_quantum QUANTUM_RST = 8'd2;

    // One queue entry held by a cell.
    typedef struct packed {
        t_pid id;
        t_svc remaining;
    } t_cell_data;

    // Per-cell commands: load has priority over shift, shift over decrement.
    typedef struct packed {
        logic load;
        logic shift;
        logic dec;
    } t_cell_ctrl;

endpackage

[hdl/rrqs_in_if.sv]
// Input channel of the scheduler: valid/ready handshake plus one item.
// Depends on rrqs_pkg for the payload types.
interface rrqs_in_if;
    logic           valid;
    logic           ready;
    logic           operation;
    rrqs_pkg::t_pid process_id;
    rrqs_pkg::t_svc service_time;

    modport source (output valid, output operation, output process_id,
                    output service_time, input ready);
    modport sink   (input valid, input operation, input process_id,
                    input service_time, output ready);
endinterface

[hdl/rrqs_out_if.sv]
// Result channel of the scheduler: valid/ready handshake plus one status item.
// Depends on rrqs_pkg for the payload types.
interface rrqs_out_if;
    logic              valid;
    logic              ready;
    rrqs_pkg::t_status status;
    rrqs_pkg::t_pid    running_process;
    rrqs_pkg::t_ftime  finish_time;
    rrqs_pkg::t_qcnt   queue_count;

    modport source (output valid, output status, output running_process,
                    output finish_time, output queue_count, input ready);
    modport sink   (input valid, input status, input running_process,
                    input finish_time, input queue_count, output ready);
endinterface

[hdl/round_robin_quantum_scheduler_core.sv]
// Round-robin quantum scheduler, top level.
// Depends on rrqs_pkg, rrqs_in_if, rrqs_out_if and rrqs_cell.
//
// Usage: the run queue is a row of MAX_PROCESSES cells; the head process
// always sits in cell 0 and the queue shifts toward it, so no pointers are
// kept. An admit (operation 0) stores the process in the first free cell and
// a tick (operation 1) runs cell 0 for one time unit. When a process uses up
// its quantum it is only marked; the move to the tail happens at the start of
// the next tick, so admits that arrive in between queue ahead of it. Every
// transfer in yields exactly one transfer out. Flow: a three-phase sequencer
// (idle, rotate, execute) handles one item at a time. An accepted item goes
// from idle to execute, where its result is registered; the tick that follows
// a preemption first passes through rotate, which shifts the row to move the
// head to the tail. Execute waits while an earlier result is still held and
// not taken. A new item is accepted only in idle, once the previous result
// has been registered, so items do not overlap. The quantum register is
// written via i_cfg_wr_en/i_cfg_wr_data and takes effect at the next reload.
module round_robin_quantum_scheduler_core #(
    parameter int MAX_PROCESSES = 16,
    parameter int TIME_BITS     = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  rrqs_pkg::t_quantum   i_cfg_wr_data,
    rrqs_in_if.sink              i_in,
    rrqs_out_if.source           o_out
);

    localparam int CW = $clog2(MAX_PROCESSES + 1);

    // Sequencer phases.
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_ROTATE = 2'd1;
    localparam logic [1:0] S_EXEC   = 2'd2;

    // Control state.
    logic [1:0]          r_state,    n_state;
    logic [CW-1:0]       r_count,    n_count;
    rrqs_pkg::t_quantum  r_quantum;
    rrqs_pkg::t_quantum  r_qleft,    n_qleft;
    logic                r_rot_pend, n_rot_pend;
    logic [TIME_BITS-1:0] r_time,    n_time;
    logic                r_out_valid, n_out_valid;

    // Latched item payload.
    logic                r_op,  n_op;
    rrqs_pkg::t_pid      r_id,  n_id;
    rrqs_pkg::t_svc      r_svc, n_svc;

    // Result payload.
    rrqs_pkg::t_status   r_status,  n_status;
    rrqs_pkg::t_pid      r_running, n_running;
    rrqs_pkg::t_ftime    r_ftime,   n_ftime;
    rrqs_pkg::t_qcnt     r_qcnt,    n_qcnt;

    // Cell row.
    rrqs_pkg::t_cell_data w_cell  [MAX_PROCESSES];
    rrqs_pkg::t_cell_data w_right [MAX_PROCESSES];
    rrqs_pkg::t_cell_ctrl w_ctrl  [MAX_PROCESSES];
    rrqs_pkg::t_cell_data w_load_data;

    logic                w_out_free;
    logic                w_full;
    logic [CW-1:0]       w_last;
    rrqs_pkg::t_svc      w_rem_next;
    rrqs_pkg::t_quantum  w_qleft_dec;

    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_full      = (r_count == CW'(MAX_PROCESSES));
    assign w_last      = r_count - 1'b1;
    assign w_rem_next  = (w_cell[0].remaining != '0) ?
                         (w_cell[0].remaining - 1'b1) : w_cell[0].remaining;
    assign w_qleft_dec = r_qleft - 1'b1;

    // Each cell takes from its right neighbor; the last cell sees an empty entry.
    genvar g;
    generate
        for (g = 0; g < MAX_PROCESSES; g++) begin : g_cells
            if (g == MAX_PROCESSES - 1) begin : g_end
                assign w_right[g] = '0;
            end else begin : g_mid
                assign w_right[g] = w_cell[g+1];
            end
            rrqs_cell u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl[g]),
                .i_right     (w_right[g]),
                .i_load_data (w_load_data),
                .o_data      (w_cell[g])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_qleft     = r_qleft;
        n_rot_pend  = r_rot_pend;
        n_time      = r_time;
        n_op        = r_op;
        n_id        = r_id;
        n_svc       = r_svc;
        n_status    = r_status;
        n_running   = r_running;
        n_ftime     = r_ftime;
        n_qcnt      = r_qcnt;
        // Drop the result once the sink takes it.
        n_out_valid = r_out_valid && !o_out.ready;

        // Admit data by default, with a zero service time taken as one.
        w_load_data.id        = r_id;
        w_load_data.remaining = (r_svc == '0) ? rrqs_pkg::t_svc'(1) : r_svc;
        for (int i = 0; i < MAX_PROCESSES; i++) begin
            w_ctrl[i] = '0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op  = i_in.operation;
                    n_id  = i_in.process_id;
                    n_svc = i_in.service_time;
                    if ((i_in.operation == rrqs_pkg::OP_TICK) && r_rot_pend &&
                        (r_count != '0)) begin
                        n_state = S_ROTATE;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end

            S_ROTATE: begin
                // Move the head to the tail: advance the row, reload the last slot.
                w_load_data = w_cell[0];
                for (int i = 0; i < MAX_PROCESSES; i++) begin
                    w_ctrl[i].load  = (CW'(i) == w_last);
                    w_ctrl[i].shift = (CW'(i) < w_last);
                end
                n_rot_pend = 1'b0;
                n_state    = S_EXEC;
            end

            S_EXEC: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_running   = '0;
                    n_state     = S_IDLE;
                    if (r_op == rrqs_pkg::OP_ADMIT) begin
                        if (w_full) begin
                            n_status = rrqs_pkg::ST_FULL_DROP;
                        end else begin
                            for (int i = 0; i < MAX_PROCESSES; i++) begin
                                w_ctrl[i].load = (CW'(i) == r_count);
                            end
                            n_count  = r_count + 1'b1;
                            n_status = rrqs_pkg::ST_ADMITTED;
                        end
                        n_ftime = rrqs_pkg::t_ftime'(r_time);
                    end else begin
                        n_time     = r_time + 1'b1;
                        n_ftime    = rrqs_pkg::t_ftime'(n_time);
                        n_rot_pend = 1'b0;
                        if (r_count == '0) begin
                            n_status = rrqs_pkg::ST_IDLE_TICK;
                        end else begin
                            n_running = w_cell[0].id;
                            if (w_rem_next == '0) begin
                                // Finished: pop the head and reload the quantum.
                                for (int i = 0; i < MAX_PROCESSES; i++) begin
                                    w_ctrl[i].shift = 1'b1;
                                end
                                n_count  = r_count - 1'b1;
                                n_qleft  = r_quantum;
                                n_status = rrqs_pkg::ST_FINISHED;
                            end else begin
                                w_ctrl[0].dec = 1'b1;
                                if (w_qleft_dec == '0) begin
                                    // Expired: mark for rotation at the next tick.
                                    n_rot_pend = 1'b1;
                                    n_qleft    = r_quantum;
                                    n_status   = rrqs_pkg::ST_PREEMPTED;
                                end else begin
                                    n_qleft  = w_qleft_dec;
                                    n_status = rrqs_pkg::ST_RAN;
                                end
                            end
                        end
                    end
                    n_qcnt = rrqs_pkg::t_qcnt'(n_count);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_quantum   <= rrqs_pkg::QUANTUM_RST;
            r_qleft     <= rrqs_pkg::QUANTUM_RST;
            r_rot_pend  <= 1'b0;
            r_time      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_qleft     <= n_qleft;
            r_rot_pend  <= n_rot_pend;
            r_time      <= n_time;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_quantum <= i_cfg_wr_data;
            end
        end
    end

    // Payload registers hold without reset.
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_id      <= n_id;
        r_svc     <= n_svc;
        r_status  <= n_status;
        r_running <= n_running;
        r_ftime   <= n_ftime;
        r_qcnt    <= n_qcnt;
    end

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_status;
    assign o_out.running_process = r_running;
    assign o_out.finish_time     = r_ftime;
    assign o_out.queue_count     = r_qcnt;

endmodule

[hdl/rrqs_cell.sv]
// One slot of the shifting run queue: holds a process id and its remaining time.
// Depends on rrqs_pkg for the entry and command structs.
module rrqs_cell (
    input  logic                 i_clk,
    input  rrqs_pkg::t_cell_ctrl i_ctrl,
    input  rrqs_pkg::t_cell_data i_right,
    input  rrqs_pkg::t_cell_data i_load_data,
    output rrqs_pkg::t_cell_data o_data
);

    rrqs_pkg::t_cell_data r_data;
    rrqs_pkg::t_cell_data n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.load) begin
            n_data = i_load_data;
        end else if (i_ctrl.shift) begin
            n_data = i_right;
        end else if (i_ctrl.dec && (r_data.remaining != '0)) begin
            n_data.remaining = r_data.remaining - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule
